// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the button repeat event queue.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// pre holds at an edge -> post holds at that same edge
`define BAE_ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: assertion failed");
// pre holds at an edge -> post holds at the next edge
`define BAE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: assertion failed");
`else
`define BAE_ASSERT_IMPLIES(label, pre, post)
`define BAE_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== src/bae_pkg.sv =====
// Shared types and constants of the button repeat event queue.
// No dependencies; imported by every module of the block.
package bae_pkg;

    // opcodes of an input beat
    localparam logic [2:0] OP_PRESS     = 3'd0;
    localparam logic [2:0] OP_RELEASE   = 3'd1;
    localparam logic [2:0] OP_TICK      = 3'd2;
    localparam logic [2:0] OP_WHEEL     = 3'd3;
    localparam logic [2:0] OP_DEQUEUE   = 3'd4;
    localparam logic [2:0] OP_MDEQUEUE  = 3'd5;
    localparam logic [2:0] OP_FMOVE     = 3'd6;

    // event codes
    localparam logic [3:0] EV_DOWN       = 4'd0;
    localparam logic [3:0] EV_UP         = 4'd1;
    localparam logic [3:0] EV_REPEAT     = 4'd2;
    localparam logic [3:0] EV_FDOWN      = 4'd3;
    localparam logic [3:0] EV_FUP        = 4'd4;
    localparam logic [3:0] EV_FREPEAT    = 4'd5;
    localparam logic [3:0] EV_WHEEL_UP   = 4'd6;
    localparam logic [3:0] EV_WHEEL_DOWN = 4'd7;
    localparam logic [3:0] EV_FMOVE      = 4'd8;
    localparam logic [3:0] NUM_CODES     = 4'd9;

    // configuration register indexes and reset values
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_DELAY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_PERIOD = 2'd3;
    localparam logic [CFG_DATA_W-1:0] RST_BTN_DELAY    = 16'd250;
    localparam logic [CFG_DATA_W-1:0] RST_BTN_PERIOD   = 16'd50;
    localparam logic [CFG_DATA_W-1:0] RST_TOUCH_DELAY  = 16'd750;
    localparam logic [CFG_DATA_W-1:0] RST_TOUCH_PERIOD = 16'd100;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  button;
        logic [31:0] now;
        logic        wheel_up;
        logic [8:0]  event_mask;
    } in_t;

    typedef struct packed {
        logic       event_valid;
        logic [3:0] event_code;
        logic [2:0] event_button;
        logic [8:0] queue_level;
        logic [2:0] dropped_count;
    } out_t;

    // one queue entry
    typedef struct packed {
        logic [3:0] code;
        logic [2:0] button;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;   // latch the input beat, clear per-item results
        logic exec;   // run a single-step item
        logic scan;   // check one button of a tick
        logic emit;   // load the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;  // current tick check is the last one
        logic out_hold;   // output register still occupied next cycle
    } ctrl_stat_t;

endpackage

// ===== src/bae_fifo.sv =====
// Ring event queue: one write port, registered read of the head entry.
// Depends on bae_pkg for the entry type.
module bae_fifo
    import bae_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  entry_t                       push_data,
    input  logic                         pop,
    output entry_t                       head_data,
    output logic [$clog2(DEPTH+1)-1:0]   level,
    output logic                         full,
    output logic                         empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    entry_t           mem [DEPTH];
    entry_t           rd_reg;
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    tail_reg;
    logic [LW-1:0]    level_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (level_reg == LW'(DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail_reg] <= push_data;
        end
        rd_reg <= mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                tail_reg <= (tail_reg == LAST) ? '0 : tail_reg + AW'(1);
            end
            if (do_pop)
            begin
                head_reg <= (head_reg == LAST) ? '0 : head_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + LW'(1);
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - LW'(1);
            end
        end
    end

    assign head_data = rd_reg;
    assign level     = level_reg;

endmodule

// ===== src/bae_dp.sv =====
// Datapath: config registers, button state, deadline adder and compare,
// event queue and output register. Depends on bae_pkg and bae_fifo.
module bae_dp
    import bae_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256,
    parameter int NUM_BUTTONS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output ctrl_stat_t            stat,
    input  in_t                   in_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [BW-1:0] FINGER = BW'(NUM_BUTTONS - 1);

    in_t                   item_reg;
    logic [CFG_DATA_W-1:0] btn_delay_reg;
    logic [CFG_DATA_W-1:0] btn_period_reg;
    logic [CFG_DATA_W-1:0] touch_delay_reg;
    logic [CFG_DATA_W-1:0] touch_period_reg;
    logic                  held_reg [NUM_BUTTONS];
    logic [31:0]           deadline_reg [NUM_BUTTONS];
    logic [BW-1:0]         scan_reg;
    logic                  ev_valid_reg;
    entry_t                ev_reg;
    logic [2:0]            drops_reg;
    logic                  out_valid_reg;
    out_t                  out_reg;

    logic [15:0]           btn_ext;
    logic                  btn_ok;
    logic [BW-1:0]         sel;
    logic                  finger;
    logic [CFG_DATA_W-1:0] amount;
    logic [31:0]           sum;
    logic [31:0]           dl_sel;
    logic                  due;
    logic                  push_req;
    entry_t                push_data;
    logic                  pop;
    logic [8:0]            mask_sh;
    logic                  mask_hit;
    entry_t                head_data;
    logic [LW-1:0]         level;
    logic                  full;
    logic                  empty;

    bae_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_req),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .level     (level),
        .full      (full),
        .empty     (empty)
    );

    // button under work: the item's button, or the tick scan order
    // (finger first, then mouse buttons in index order)
    always_comb
    begin
        btn_ext = {13'b0, item_reg.button};
        btn_ok  = (btn_ext < 16'(NUM_BUTTONS));
        if (cmd.scan)
        begin
            sel = (scan_reg == '0) ? FINGER : scan_reg - BW'(1);
        end
        else
        begin
            sel = btn_ext[BW-1:0];
        end
        finger = (sel == FINGER);
        if (cmd.scan)
        begin
            amount = finger ? touch_period_reg : btn_period_reg;
        end
        else
        begin
            amount = finger ? touch_delay_reg : btn_delay_reg;
        end
        sum    = item_reg.now + {16'b0, amount};
        dl_sel = deadline_reg[sel];
        due    = held_reg[sel] && (dl_sel != '0) && (dl_sel <= item_reg.now);
    end

    always_comb
    begin
        mask_sh  = item_reg.event_mask >> head_data.code;
        mask_hit = (head_data.code < NUM_CODES) && mask_sh[0];
        push_req = 1'b0;
        push_data = '0;
        pop      = 1'b0;
        if (cmd.exec)
        begin
            unique case (item_reg.opcode)
                OP_PRESS:
                begin
                    push_req  = btn_ok;
                    push_data = '{code: finger ? EV_FDOWN : EV_DOWN, button: item_reg.button};
                end
                OP_RELEASE:
                begin
                    push_req  = btn_ok;
                    push_data = '{code: finger ? EV_FUP : EV_UP, button: item_reg.button};
                end
                OP_WHEEL:
                begin
                    push_req  = 1'b1;
                    push_data = '{code: item_reg.wheel_up ? EV_WHEEL_UP : EV_WHEEL_DOWN,
                                  button: 3'd0};
                end
                OP_FMOVE:
                begin
                    push_req  = 1'b1;
                    push_data = '{code: EV_FMOVE, button: 3'd0};
                end
                OP_DEQUEUE:
                begin
                    pop = !empty;
                end
                OP_MDEQUEUE:
                begin
                    pop = !empty && mask_hit;
                end
                default:
                begin
                    pop = 1'b0;
                end
            endcase
        end
        else if (cmd.scan && due)
        begin
            push_req  = 1'b1;
            push_data = '{code: finger ? EV_FREPEAT : EV_REPEAT, button: 3'(sel)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btn_delay_reg    <= RST_BTN_DELAY;
            btn_period_reg   <= RST_BTN_PERIOD;
            touch_delay_reg  <= RST_TOUCH_DELAY;
            touch_period_reg <= RST_TOUCH_PERIOD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BTN_DELAY:    btn_delay_reg    <= cfg_data;
                CFG_BTN_PERIOD:   btn_period_reg   <= cfg_data;
                CFG_TOUCH_DELAY:  touch_delay_reg  <= cfg_data;
                CFG_TOUCH_PERIOD: touch_period_reg <= cfg_data;
                default:          btn_delay_reg    <= btn_delay_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                held_reg[i]     <= 1'b0;
                deadline_reg[i] <= '0;
            end
        end
        else if (cmd.exec && btn_ok && (item_reg.opcode == OP_PRESS))
        begin
            held_reg[sel]     <= 1'b1;
            deadline_reg[sel] <= sum;
        end
        else if (cmd.exec && btn_ok && (item_reg.opcode == OP_RELEASE))
        begin
            held_reg[sel]     <= 1'b0;
            deadline_reg[sel] <= '0;
        end
        else if (cmd.scan)
        begin
            if (!held_reg[sel])
            begin
                deadline_reg[sel] <= '0;
            end
            else if (due)
            begin
                deadline_reg[sel] <= sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= '0;
            ev_valid_reg  <= 1'b0;
            ev_reg        <= '0;
            drops_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                scan_reg     <= '0;
                ev_valid_reg <= 1'b0;
                ev_reg       <= '0;
                drops_reg    <= '0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    scan_reg <= scan_reg + BW'(1);
                end
                if (pop)
                begin
                    ev_valid_reg <= 1'b1;
                    ev_reg       <= head_data;
                end
                if (push_req && full)
                begin
                    drops_reg <= drops_reg + 3'd1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.event_valid   <= ev_valid_reg;
            out_reg.event_code    <= ev_reg.code;
            out_reg.event_button  <= ev_reg.button;
            out_reg.queue_level   <= 9'(level);
            out_reg.dropped_count <= drops_reg;
        end
    end

    assign stat.scan_last = (scan_reg == BW'(NUM_BUTTONS - 1));
    assign stat.out_hold  = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;

endmodule

// ===== src/bae_ctrl.sv =====
// Sequencer of the button repeat event queue: accept, execute or scan, emit.
// Depends on bae_pkg for the state, command and status types.
module bae_ctrl
    import bae_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] opcode,
    output logic       in_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (opcode == OP_TICK) ? ST_TICK : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_TICK:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!stat.out_hold)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/button_autorepeat_event_queue.sv =====
// Top level of the button repeat event queue: sequencer plus datapath.
// Depends on bae_pkg, bae_ctrl, bae_dp and assert_macros.svh.
//
// Usage:
//   in_valid/in_ready/in_data carry one item per beat (press, release, tick,
//   wheel, dequeue, masked dequeue, finger move). Every item returns exactly
//   one beat on out_valid/out_ready/out_data with the dequeued event (if any),
//   the queue level after the item and the events dropped on a full queue.
//   cfg_we/cfg_index/cfg_data write the delay and period registers; write only
//   while no item is in flight.
//   The accepted item is latched; a tick then scans the buttons, any other
//   item is executed, then the result is loaded. The tick walks the buttons
//   one per cycle through a single deadline adder and compare and a single
//   queue write port; the next item is accepted in the cycle after that load.
//   If the receiver stalls, the result waits in the output register while the
//   next item is accepted and worked; that item's result then waits in the
//   sequencer until the output register frees.
//   Reset: all buttons released, deadlines disarmed, queue empty, registers
//   back to 250/50/750/100. Queue storage is not cleared, no sweep is needed.
`include "assert_macros.svh"
module button_autorepeat_event_queue
    import bae_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256,
    parameter int NUM_BUTTONS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    bae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (in_data.opcode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bae_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // one item at a time: after an accept the block is busy
    `BAE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // no event returned -> code and button zero
    `BAE_ASSERT_IMPLIES(a_empty_result, out_valid && !out_data.event_valid, (out_data.event_code == 4'd0) && (out_data.event_button == 3'd0))
    // only defined codes come out of the queue
    `BAE_ASSERT_IMPLIES(a_code_range, out_valid && out_data.event_valid, out_data.event_code < NUM_CODES)
    // drops happen only with the queue full
    `BAE_ASSERT_IMPLIES(a_drop_full, out_valid && (out_data.dropped_count != 3'd0), out_data.queue_level == 9'(QUEUE_DEPTH))

endmodule
